>>> hdl/imh_pkg.sv
package imh_pkg;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_POS,
    ST_CHK_POS,
    ST_CHK_ENT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_X_ROOT,
    ST_X_LAST,
    ST_X_SET,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

  localparam int VTX_BITS    = 8;
  localparam int IN_KEY_BITS = 31;
  localparam int IN_BITS     = 41;
  localparam int IN_PAD      = 48;
  localparam int OUT_BITS    = 43;
  localparam int OUT_PAD     = 48;

  // first field sits in the highest bits, last field in the lowest
  typedef struct packed {
    logic                   now_empty;
    logic                   ignored;
    logic                   in_heap;
    logic                   was_empty;
    logic [IN_KEY_BITS-1:0] out_key;
    logic [VTX_BITS-1:0]    out_vertex;
  } res_t;

endpackage

>>> hdl/imh_ram.sv
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/indexed_min_heap_core.sv
// Channel   Dir  Payload (tdata, lowest bit first)
// s_axis    in   opcode[1:0] vertex[9:2] new_key[40:10], zero pad to 48
// m_axis    out  out_vertex out_key was_empty in_heap ignored now_empty, pad to 48
//
// One word at a time; the block returns to idle before the next accept.
// Query, load and decrease-key read the map entry, then the heap entry; a
// decrease-key that applies then climbs, reading and comparing each parent.
// Extract-min on an empty heap finishes directly; else it takes the root,
// moves the last entry there and descends, reading the left then the right
// child per level on the single heap RAM read port. Reset clears the count,
// the loaded marks and control; RAM contents are don't-care until written.
// A stalled result holds the block in its final state until m_axis_tready.
module indexed_min_heap_core #(
  parameter int MAX_VERTICES = 256,
  parameter int KEY_BITS     = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // opcode, vertex, new_key
  input  logic [imh_pkg::IN_PAD-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_vertex, out_key, was_empty, in_heap, ignored, now_empty
  output logic [imh_pkg::OUT_PAD-1:0]  m_axis_tdata
);
  import imh_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int EW = VTX_BITS + KEY_BITS;

  state_t state, state_next;
  op_t op;
  logic [VTX_BITS-1:0] vtx;
  logic [KEY_BITS-1:0] key;
  logic [IW:0]         cnt;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       ppos;
  logic [EW-1:0]       cur;
  logic [EW-1:0]       lchild;
  res_t                res;
  res_t                res_done;
  logic                out_valid;
  res_t                out_data;
  // vertices loaded at least once; their map entries are defined
  logic [MAX_VERTICES-1:0] seen;

  logic          heap_we, pos_we;
  logic [IW-1:0] heap_waddr, heap_raddr, pos_waddr, pos_raddr;
  logic [EW-1:0] heap_wdata, heap_rdata;
  logic [IW-1:0] pos_wdata, pos_rdata;

  logic                accept, out_free, present, v_ok, cnt_room;
  logic [IW:0]         lidx;
  logic [IW+1:0]       ridx;
  logic                l_ok, r_ok, take_l, take_r, up_move;
  logic [KEY_BITS-1:0] ckey, lkey, rkey, bkey;
  logic [EW-1:0]       child;
  logic [IW-1:0]       cidx, pidx;

  imh_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  imh_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_PAD-OUT_BITS){1'b0}}, out_data};

  assign v_ok     = (32'(vtx) < MAX_VERTICES);
  assign cnt_room = (32'(cnt) < MAX_VERTICES);
  assign present  = v_ok && seen[IW'(vtx)] && ({1'b0, ppos} < cnt) &&
                    (heap_rdata[EW-1 -: VTX_BITS] == vtx);

  assign lidx = {idx, 1'b1};
  assign ridx = {1'b0, idx, 1'b0} + (IW+2)'(2);
  assign l_ok = lidx < cnt;
  assign r_ok = ridx < {1'b0, cnt};
  assign pidx = IW'((idx - 1'b1) >> 1);

  assign ckey    = cur[KEY_BITS-1:0];
  assign lkey    = lchild[KEY_BITS-1:0];
  assign rkey    = heap_rdata[KEY_BITS-1:0];
  assign take_l  = lkey < ckey;
  assign bkey    = take_l ? lkey : ckey;
  assign take_r  = r_ok && (rkey < bkey);
  assign child   = take_r ? heap_rdata : lchild;
  assign cidx    = take_r ? ridx[IW-1:0] : lidx[IW-1:0];
  assign up_move = ckey < heap_rdata[KEY_BITS-1:0];

  always_comb begin
    res_done           = res;
    res_done.now_empty = (cnt == '0);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (op_t'(s_axis_tdata[1:0]) == OP_EXTRACT) ? ST_X_ROOT : ST_RD_POS;
        end
      end
      ST_RD_POS:  state_next = ST_CHK_POS;
      ST_CHK_POS: state_next = ST_CHK_ENT;
      ST_CHK_ENT: begin
        state_next = (op == OP_DECREASE && present) ? ST_UP_RD : ST_FINISH;
      end
      ST_UP_RD:   state_next = (idx == '0) ? ST_FINISH : ST_UP_CMP;
      ST_UP_CMP:  state_next = up_move ? ST_UP_RD : ST_FINISH;
      ST_X_ROOT:  state_next = (cnt == '0) ? ST_FINISH : ST_X_LAST;
      ST_X_LAST:  state_next = ST_X_SET;
      ST_X_SET:   state_next = ST_DN_L;
      ST_DN_L:    state_next = l_ok ? ST_DN_R : ST_FINISH;
      ST_DN_R:    state_next = ST_DN_CMP;
      ST_DN_CMP:  state_next = (take_l || take_r) ? ST_DN_L : ST_FINISH;
      ST_FINISH:  state_next = out_free ? ST_IDLE : ST_FINISH;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    heap_raddr = '0;
    pos_raddr  = IW'(vtx);
    heap_we    = 1'b0;
    heap_waddr = idx;
    heap_wdata = cur;
    pos_we     = 1'b0;
    pos_waddr  = IW'(cur[EW-1 -: VTX_BITS]);
    pos_wdata  = idx;
    case (state)
      ST_CHK_POS: heap_raddr = pos_rdata;
      ST_CHK_ENT: begin
        if (op == OP_LOAD && !present && v_ok && cnt_room) begin
          heap_we    = 1'b1;
          heap_waddr = cnt[IW-1:0];
          heap_wdata = {vtx, key};
          pos_we     = 1'b1;
          pos_waddr  = IW'(vtx);
          pos_wdata  = cnt[IW-1:0];
        end
      end
      ST_UP_RD: begin
        heap_raddr = pidx;
        if (idx == '0) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      ST_UP_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (up_move) begin
          heap_wdata = heap_rdata;
          pos_waddr  = IW'(heap_rdata[EW-1 -: VTX_BITS]);
        end
      end
      ST_X_LAST: heap_raddr = IW'(cnt - 1'b1);
      ST_X_SET: begin
        // removed vertex points past the end, so it reads as absent
        pos_we    = 1'b1;
        pos_waddr = IW'(res.out_vertex);
        pos_wdata = IW'(cnt - 1'b1);
      end
      ST_DN_L: begin
        heap_raddr = lidx[IW-1:0];
        if (!l_ok) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      ST_DN_R: heap_raddr = ridx[IW-1:0];
      ST_DN_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (take_l || take_r) begin
          heap_wdata = child;
          pos_waddr  = IW'(child[EW-1 -: VTX_BITS]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      seen      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CHK_ENT: begin
          if (op == OP_LOAD && !present && v_ok && cnt_room) begin
            cnt             <= cnt + 1'b1;
            seen[IW'(vtx)]  <= 1'b1;
          end
        end
        ST_X_SET: cnt <= cnt - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op  <= op_t'(s_axis_tdata[1:0]);
          vtx <= s_axis_tdata[9:2];
          key <= KEY_BITS'(s_axis_tdata[40:10]);
          res <= '0;
        end
      end
      ST_CHK_POS: ppos <= pos_rdata;
      ST_CHK_ENT: begin
        cur <= {vtx, key};
        idx <= ppos;
        case (op)
          OP_LOAD:     res.ignored <= present || !v_ok || !cnt_room;
          OP_DECREASE: res.ignored <= !present;
          OP_QUERY:    res.in_heap <= present;
          default: ;
        endcase
      end
      ST_UP_CMP: begin
        if (up_move) begin
          idx <= pidx;
        end
      end
      ST_X_ROOT: begin
        if (cnt == '0) begin
          res.was_empty <= 1'b1;
        end
      end
      ST_X_LAST: begin
        res.out_vertex <= heap_rdata[EW-1 -: VTX_BITS];
        res.out_key    <= IN_KEY_BITS'(heap_rdata[KEY_BITS-1:0]);
      end
      ST_X_SET: begin
        cur <= heap_rdata;
        idx <= '0;
      end
      ST_DN_R: lchild <= heap_rdata;
      ST_DN_CMP: begin
        if (take_l || take_r) begin
          idx <= cidx;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_data <= res_done;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= MAX_VERTICES)
    else $error("heap count above capacity");

  a_cnt_src: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (cnt != $past(cnt)) |->
      ($past(state) == ST_CHK_ENT || $past(state) == ST_X_SET))
    else $error("heap count changed outside load or extract");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    heap_we && state != ST_CHK_ENT |-> ({1'b0, heap_waddr} < cnt || cnt == '0))
    else $error("heap write beyond live entries");

  a_dn_idx: assert property (@(posedge clk) disable iff (rst)
    state == ST_DN_L |-> ({1'b0, idx} < cnt || idx == '0))
    else $error("sift-down index beyond count");
`endif

endmodule
